// File: rtl/round_robin_time_slicer_macros.svh
// Assertion macros for the round-robin time slicer
`ifndef ROUND_ROBIN_TIME_SLICER_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICER_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");
`else
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/rrts_pkg.sv
package rrts_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int PEND_W   = 5;
    localparam int STATUS_W = 2;
    localparam int ENT_W    = ID_W + TIME_W;

    localparam logic [TIME_W-1:0] QUANTUM_RST = TIME_W'(3);

    typedef enum logic {
        KIND_ADD = 1'b0,
        KIND_RUN = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED  = 2'd0,
        STS_REJECT = 2'd1,
        STS_RAN    = 2'd2,
        STS_IDLE   = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// File: rtl/rrts_if.sv
interface rrts_cmd_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [rrts_pkg::ID_W-1:0]   job_id;
    logic [rrts_pkg::TIME_W-1:0] job_time;

    modport source (output valid, kind, job_id, job_time, input ready);
    modport sink   (input valid, kind, job_id, job_time, output ready);
endinterface

interface rrts_res_if;
    logic                         valid;
    logic                         ready;
    logic [rrts_pkg::STATUS_W-1:0] status;
    logic [rrts_pkg::ID_W-1:0]     ran_id;
    logic [rrts_pkg::TIME_W-1:0]   ran_time;
    logic [rrts_pkg::TIME_W-1:0]   left_time;
    logic                         finished;
    logic [rrts_pkg::PEND_W-1:0]   pending;

    modport source (output valid, status, ran_id, ran_time, left_time, finished, pending,
                    input ready);
    modport sink   (input valid, status, ran_id, ran_time, left_time, finished, pending,
                    output ready);
endinterface

interface rrts_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rrts_pkg::TIME_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/round_robin_time_slicer.sv
// Flow: an accepted word and the head entry read from the job RAM are registered at the accepting
// edge; the round then executes in the EXEC state and its result is registered (o_res.valid high).
// A new word is accepted only in the IDLE state, so no new word is taken until the round of the
// last one has executed; the round is held in EXEC while an earlier result word waits.
// Reset: synchronous, active low; clears head, tail, job count and output valid, sets the quantum to 3.
// Job RAM contents are not cleared and need no clearing pass.
module round_robin_time_slicer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrts_cmd_if.sink   i_cmd,
    rrts_res_if.source o_res,
    rrts_cfg_if.sink   i_cfg
);

    rrts_pkg::t_cmd cmd;
    rrts_pkg::t_sts sts;
    logic           in_ready;

    assign i_cmd.ready = in_ready;

    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrts_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_word  (i_cmd),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule

// File: rtl/rrts_ram.sv
module rrts_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                   i_wdata,
    input  logic                           i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                   o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rrts_ctrl.sv
`include "round_robin_time_slicer_macros.svh"

module rrts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = i_in_valid && (r_state == S_IDLE);
        o_cmd.exec = (r_state == S_EXEC) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RRTS_ASSERT_NXT(a_load_to_exec, i_clk, i_rst_n, o_cmd.load, r_state == S_EXEC)
    `RRTS_ASSERT_NXT(a_exec_waits, i_clk, i_rst_n, (r_state == S_EXEC) && !i_sts.out_free, r_state == S_EXEC)

endmodule

// File: rtl/rrts_dp.sv
`include "round_robin_time_slicer_macros.svh"

module rrts_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrts_pkg::t_cmd i_cmd,
    output rrts_pkg::t_sts o_sts,
    rrts_cmd_if.sink       i_word,
    rrts_res_if.source     o_res,
    rrts_cfg_if.sink       i_cfg
);

    localparam int DEPTH  = rrts_pkg::DEPTH;
    localparam int PTR_W  = rrts_pkg::PTR_W;
    localparam int CNT_W  = rrts_pkg::CNT_W;
    localparam int ID_W   = rrts_pkg::ID_W;
    localparam int TIME_W = rrts_pkg::TIME_W;
    localparam int PEND_W = rrts_pkg::PEND_W;
    localparam int ENT_W  = rrts_pkg::ENT_W;

    rrts_pkg::t_kind    r_kind;
    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_time;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]  r_quantum;
    logic               r_out_valid, n_out_valid;
    rrts_pkg::t_status  r_status, n_status;
    logic [ID_W-1:0]    r_ran_id, n_ran_id;
    logic [TIME_W-1:0]  r_ran_time, n_ran_time;
    logic [TIME_W-1:0]  r_left_time, n_left_time;
    logic               r_finished, n_finished;
    logic [PEND_W-1:0]  r_pending, n_pending;

    logic               we;
    logic [ENT_W-1:0]   wdata;
    logic [ENT_W-1:0]   rdata;
    logic [ID_W-1:0]    rd_id;
    logic [TIME_W-1:0]  rd_rem;
    logic [TIME_W-1:0]  q_eff;
    logic [TIME_W-1:0]  slice;
    logic [TIME_W-1:0]  left;
    logic               full;
    logic               empty;

    rrts_ram #(
        .W (ENT_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_re    (i_cmd.load),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign rd_id  = rdata[ENT_W-1:TIME_W];
    assign rd_rem = rdata[TIME_W-1:0];
    assign q_eff  = (r_quantum == '0) ? TIME_W'(1) : r_quantum;
    assign slice  = (rd_rem < q_eff) ? rd_rem : q_eff;
    assign left   = rd_rem - slice;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    assign o_sts.out_free = !r_out_valid || o_res.ready;
    assign i_cfg.ready    = 1'b1;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_ran_id    = r_ran_id;
        n_ran_time  = r_ran_time;
        n_left_time = r_left_time;
        n_finished  = r_finished;
        n_pending   = r_pending;
        we          = 1'b0;
        wdata       = {r_id, r_time};
        if (i_cmd.exec) begin
            n_out_valid = 1'b1;
            n_ran_id    = '0;
            n_ran_time  = '0;
            n_left_time = '0;
            n_finished  = 1'b0;
            case (r_kind)
                rrts_pkg::KIND_ADD: begin
                    if (full) begin
                        n_status = rrts_pkg::STS_REJECT;
                    end else begin
                        we       = 1'b1;
                        n_tail   = rrts_pkg::next_ptr(r_tail);
                        n_count  = r_count + 1'b1;
                        n_status = rrts_pkg::STS_ADDED;
                    end
                end
                rrts_pkg::KIND_RUN: begin
                    if (empty) begin
                        n_status = rrts_pkg::STS_IDLE;
                    end else begin
                        n_status    = rrts_pkg::STS_RAN;
                        n_head      = rrts_pkg::next_ptr(r_head);
                        n_ran_id    = rd_id;
                        n_ran_time  = slice;
                        n_left_time = left;
                        if (left != '0) begin
                            // requeue at tail; the popped head slot frees room
                            we     = 1'b1;
                            wdata  = {rd_id, left};
                            n_tail = rrts_pkg::next_ptr(r_tail);
                        end else begin
                            n_count    = r_count - 1'b1;
                            n_finished = 1'b1;
                        end
                    end
                end
                default: begin
                    n_status = rrts_pkg::STS_IDLE;
                end
            endcase
            n_pending = PEND_W'(n_count);
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_quantum   <= rrts_pkg::QUANTUM_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_quantum <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= rrts_pkg::t_kind'(i_word.kind);
            r_id   <= i_word.job_id;
            r_time <= i_word.job_time;
        end
        r_status    <= n_status;
        r_ran_id    <= n_ran_id;
        r_ran_time  <= n_ran_time;
        r_left_time <= n_left_time;
        r_finished  <= n_finished;
        r_pending   <= n_pending;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_status;
    assign o_res.ran_id    = r_ran_id;
    assign o_res.ran_time  = r_ran_time;
    assign o_res.left_time = r_left_time;
    assign o_res.finished  = r_finished;
    assign o_res.pending   = r_pending;

    `RRTS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `RRTS_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, empty, r_head == r_tail)
    `RRTS_ASSERT_NXT(a_retire_dec, i_clk, i_rst_n, i_cmd.exec && (r_kind == rrts_pkg::KIND_RUN) && !empty && (left == '0), r_count == ($past(r_count) - 1'b1))
    `RRTS_ASSERT_NXT(a_exec_result, i_clk, i_rst_n, i_cmd.exec, r_out_valid)

endmodule
